>>> rtl/word_hash_direct_table_macros.svh
// Assertion macros used by the word hash table RTL.
`ifndef WORD_HASH_DIRECT_TABLE_MACROS_SVH
`define WORD_HASH_DIRECT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// ante holding at an edge implies cons at the same edge
`define WHDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// ante holding at an edge implies cons at the next edge
`define WHDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WHDT_ASSERT_IMP(lbl, ante, cons, msg)
`define WHDT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/whdt_pkg.sv
// Types, codes and byte classes for the word hash table.
package whdt_pkg;

  localparam int WHDT_SLOTS    = 64;
  localparam int WHDT_MAX_WORD = 128;
  localparam int CFG_W         = 7;
  localparam int MIN_WORD      = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] ACT_EMPTY = 2'd0;
  localparam logic [1:0] ACT_DIFF  = 2'd1;
  localparam logic [1:0] ACT_SAME  = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
    logic [5:0] read_slot;
    logic [6:0] read_pos;
  } whdt_in_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] slot;
    logic [1:0] action;
    logic [7:0] word_len;
    logic [7:0] read_char;
  } whdt_out_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
           (c >= 8'd97 && c <= 8'd122);
  endfunction

  // control, space or punctuation: below 128 and not alphanumeric
  function automatic logic ends_word(input logic [7:0] c);
    return !c[7] && !is_alnum(c);
  endfunction

endpackage

>>> rtl/word_hash_direct_table.sv
// Top level of the word hash table: sequencer, word buffer, slot store.
`include "word_hash_direct_table_macros.svh"

// Text bytes arrive one beat at a time. Letters and digits grow the current
// word (up to MAX_WORD bytes, the rest dropped); a byte of 128 or above
// restarts the word with itself; any other byte ends it. A word of three or
// more bytes is hashed as its byte sum modulo slots_in_use (0 acts as 1,
// values above SLOTS act as SLOTS) and copied over that slot, giving one
// result beat with the slot and whether it was empty, held a word of another
// length, or one of the same length. A read beat returns one stored byte and
// the slot's length. A placed word waits on the bit-serial remainder unit
// (one bit of the 15-bit sum a cycle) and on the byte-wide copy through the
// single write port of the slot store. After reset the slot length memory
// is swept to zero with in_stall high; configuration beats are taken
// throughout. The result register lets the next beat in while a result
// waits; a new result waits only if the previous one has not yet been taken.
module word_hash_direct_table #(
  parameter int SLOTS    = whdt_pkg::WHDT_SLOTS,
  parameter int MAX_WORD = whdt_pkg::WHDT_MAX_WORD
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  whdt_pkg::whdt_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output whdt_pkg::whdt_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [whdt_pkg::CFG_W-1:0] cfg_data
);
  import whdt_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW    = $clog2(MAX_WORD);
  localparam int LW    = $clog2(MAX_WORD + 1);
  localparam int SUM_W = $clog2(MAX_WORD * 255 + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD_WAIT, S_DIVIDE, S_LOOKUP, S_COPY, S_EMIT
  } state_t;

  state_t           state_r;
  logic [CFG_W-1:0] cfg_r;
  logic [LW-1:0]    len_r;
  logic [SUM_W-1:0] sum_r;
  logic [SW-1:0]    idx_r;
  logic [SW-1:0]    clr_r;
  logic [PW-1:0]    cnt_r;
  logic [5:0]       rs_r;
  logic [6:0]       rp_r;
  logic             rs_ok_r;
  whdt_out_t        res_r;
  logic             out_valid_r;
  whdt_out_t        out_data_r;

  // memories and their ports
  logic [7:0]    buf_mem [MAX_WORD];
  logic [7:0]    buf_q_r;
  logic          buf_we;
  logic [PW-1:0] buf_waddr;
  logic [PW-1:0] buf_raddr;

  logic [7:0]       store_mem [SLOTS * (2 ** PW)];
  logic [7:0]       store_q_r;
  logic             store_we;
  logic [SW+PW-1:0] store_waddr;
  logic [SW+PW-1:0] store_raddr;

  logic [LW-1:0] slen_mem [SLOTS];
  logic [LW-1:0] slen_q_r;
  logic          slen_we;
  logic [SW-1:0] slen_waddr;
  logic [LW-1:0] slen_wdata;
  logic [SW-1:0] slen_raddr;

  logic             acc;
  logic             is_text;
  logic [7:0]       c;
  logic             mod_start;
  logic             mod_done;
  logic [CFG_W-1:0] mod_rem;
  logic [CFG_W-1:0] div_eff;
  logic             copy_last;
  logic             out_free;
  logic [LW-1:0]    rd_len;

  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign is_text   = (in_data.command == CMD_TEXT);
  assign c         = in_data.byte_value;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // divisor clamped into 1..SLOTS
  always_comb begin
    if (cfg_r == '0) begin
      div_eff = CFG_W'(1);
    end else if (int'(cfg_r) > SLOTS) begin
      div_eff = CFG_W'(SLOTS);
    end else begin
      div_eff = cfg_r;
    end
  end

  assign mod_start = acc && is_text && ends_word(c) && (int'(len_r) >= MIN_WORD);

  whdt_mod_unit #(
    .MAX_WORD (MAX_WORD)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (sum_r),
    .divisor   (div_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign copy_last = ((LW'(cnt_r) + LW'(1)) == len_r);

  // memory port steering
  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = PW'(len_r);
    if (acc && is_text && !is_alnum(c) && !ends_word(c)) begin
      buf_we    = 1'b1;
      buf_waddr = '0;
    end else if (acc && is_text && is_alnum(c) && (int'(len_r) < MAX_WORD)) begin
      buf_we    = 1'b1;
    end
    buf_raddr = (state_r == S_COPY) ? PW'(cnt_r + PW'(1)) : '0;

    store_we    = (state_r == S_COPY);
    store_waddr = {idx_r, cnt_r};
    store_raddr = {SW'(in_data.read_slot), PW'(in_data.read_pos)};

    slen_we    = (state_r == S_CLEAR) || (state_r == S_LOOKUP);
    slen_waddr = (state_r == S_CLEAR) ? clr_r : idx_r;
    slen_wdata = (state_r == S_CLEAR) ? '0 : len_r;
    slen_raddr = (state_r == S_DIVIDE) ? SW'(mod_rem) : SW'(in_data.read_slot);
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= c;
    end
    buf_q_r <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= buf_q_r;
    end
    store_q_r <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (slen_we) begin
      slen_mem[slen_waddr] <= slen_wdata;
    end
    slen_q_r <= slen_mem[slen_raddr];
  end

  assign rd_len = rs_ok_r ? slen_q_r : '0;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      len_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in emit the result register is reloaded below
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + SW'(1);
          if (clr_r == SW'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            if (!is_text) begin
              rs_r    <= in_data.read_slot;
              rp_r    <= in_data.read_pos;
              rs_ok_r <= (int'(in_data.read_slot) < SLOTS);
              state_r <= S_RD_WAIT;
            end else if (is_alnum(c)) begin
              if (int'(len_r) < MAX_WORD) begin
                len_r <= len_r + LW'(1);
                sum_r <= sum_r + SUM_W'(c);
              end
            end else if (!ends_word(c)) begin
              // high byte: drop the word so far and start afresh
              len_r <= LW'(1);
              sum_r <= SUM_W'(c);
            end else if (mod_start) begin
              state_r <= S_DIVIDE;
            end else begin
              len_r <= '0;
              sum_r <= '0;
            end
          end
        end
        S_RD_WAIT: begin
          res_r.kind      <= KIND_READ;
          res_r.slot      <= rs_r;
          res_r.action    <= ACT_EMPTY;
          res_r.word_len  <= 8'(rd_len);
          res_r.read_char <= (int'(rp_r) < int'(rd_len)) ? store_q_r : 8'd0;
          state_r         <= S_EMIT;
        end
        S_DIVIDE: begin
          if (mod_done) begin
            idx_r   <= SW'(mod_rem);
            state_r <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          res_r.kind      <= KIND_WORD;
          res_r.slot      <= 6'(idx_r);
          res_r.word_len  <= 8'(len_r);
          res_r.read_char <= 8'd0;
          if (slen_q_r == '0) begin
            res_r.action <= ACT_EMPTY;
          end else if (slen_q_r != len_r) begin
            res_r.action <= ACT_DIFF;
          end else begin
            res_r.action <= ACT_SAME;
          end
          cnt_r   <= '0;
          state_r <= S_COPY;
        end
        S_COPY: begin
          cnt_r <= cnt_r + PW'(1);
          if (copy_last) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            if (res_r.kind == KIND_WORD) begin
              len_r <= '0;
              sum_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WHDT_ASSERT_IMP(a_out_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT, "result without emit")
  `WHDT_ASSERT_IMP(a_done_in_divide, mod_done, state_r == S_DIVIDE, "remainder done outside divide")
  `WHDT_ASSERT_NXT(a_start_to_divide, mod_start, state_r == S_DIVIDE, "word end did not start divide")
  `WHDT_ASSERT_IMP(a_copy_in_range, state_r == S_COPY, int'(cnt_r) < int'(len_r), "copy overran word")

endmodule

>>> rtl/whdt_mod_unit.sv
// Bit-serial restoring remainder unit: dividend modulo a 7-bit divisor.
module whdt_mod_unit #(
  parameter  int MAX_WORD = whdt_pkg::WHDT_MAX_WORD,
  localparam int SUM_W    = $clog2(MAX_WORD * 255 + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SUM_W-1:0]           dividend,
  input  logic [whdt_pkg::CFG_W-1:0] divisor,
  output logic                       done,
  output logic [whdt_pkg::CFG_W-1:0] remainder
);
  import whdt_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] dvd_r;
  logic [CFG_W-1:0] div_r;
  logic [CFG_W-1:0] rem_r;
  logic [CFG_W-1:0] rem_nxt;
  logic [CFG_W:0]   trial;

  // one quotient bit a cycle: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[SUM_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CFG_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = CFG_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
